### rtl/cdeq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cdeq_pkg - shared definitions for the double-ended byte queue
// Request codes, field widths and the per-cycle command that goes to each cell.
// ============================================================================
package cdeq_pkg;

    // Default ring depth; the queue holds DEPTH-1 bytes
    localparam int DEPTH_DEFAULT = 128;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int OCC_W    = 7;

    // Stream word widths (padded to whole bytes)
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } cdeq_action_t;

    // Command broadcast to every cell; only set when the request succeeds
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cdeq_cmd_t;

endpackage

### rtl/circular_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// circular_double_ended_queue_unit - double-ended byte queue
// Push or pop a byte at either end; each request returns the popped byte,
// a success flag, the occupancy and the empty / full flags.
// ============================================================================
//
// Channel   Dir   Fields (tdata, lowest bit up)
// s_axis    in    action[1:0], data_in[9:2], zero pad to 16 bits
// m_axis    out   data_out[7:0], ok[8], occupancy[15:9], is_empty[16],
//                 is_full[17], zero pad to 24 bits
//
// Each request is taken into a chain of DEPTH-1 cells that shift or append
// in the cycle of the transfer, and its result appears
// in the output register on the next cycle.
// One request per cycle is sustained while m_tready stays high; a stalled
// result holds s_tready low until it is taken.
// rst_n clears the count and the output valid; cell contents are not reset.
// ============================================================================
module circular_double_ended_queue_unit #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cdeq_pkg::IN_TDATA_W-1:0]    s_tdata,   // action, data_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdeq_pkg::OUT_TDATA_W-1:0]   m_tdata    // data_out, ok, occupancy,
                                                          // is_empty, is_full
);

    localparam int CW     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int NCELLS = DEPTH - 1;
    localparam int BW     = cdeq_pkg::BYTE_W;
    localparam int OW     = cdeq_pkg::OCC_W;

    // input fields
    cdeq_pkg::cdeq_action_t action;
    logic [BW-1:0]          data_in;
    logic                   in_xfer;

    assign action  = cdeq_pkg::cdeq_action_t'(s_tdata[cdeq_pkg::ACTION_W-1:0]);
    assign data_in = s_tdata[cdeq_pkg::ACTION_W +: BW];

    // occupancy and output registers
    logic [CW-1:0]  count_reg, count_next;
    logic           out_valid_reg;
    logic [BW-1:0]  data_out_reg, data_out_next;
    logic           ok_reg, ok_next;
    logic [OW-1:0]  occ_reg;
    logic           empty_reg, full_reg;

    logic                 is_empty, is_full;
    cdeq_pkg::cdeq_cmd_t  cmd;

    logic [BW-1:0] f_val [NCELLS];
    logic [BW-1:0] b_val [NCELLS];

    logic [OW+CW-1:0] occ_ext;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH - 1));

    // request decode
    always_comb
    begin
        cmd           = '0;
        ok_next       = 1'b0;
        data_out_next = '0;
        count_next    = count_reg;
        if (in_xfer)
        begin
            unique case (action)
                cdeq_pkg::ACT_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        cmd.push_front = 1'b1;
                        ok_next        = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                end
                cdeq_pkg::ACT_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        cmd.push_back = 1'b1;
                        ok_next       = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                end
                cdeq_pkg::ACT_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        cmd.pop_front = 1'b1;
                        ok_next       = 1'b1;
                        data_out_next = f_val[0];
                        count_next    = count_reg - CW'(1);
                    end
                end
                cdeq_pkg::ACT_POP_BACK:
                begin
                    if (!is_empty)
                    begin
                        cmd.pop_back  = 1'b1;
                        ok_next       = 1'b1;
                        data_out_next = b_val[0];
                        count_next    = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    // occupancy field: low bits of the count, zero-extended for small depths
    assign occ_ext = {{OW{1'b0}}, count_next};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_out_reg <= data_out_next;
            ok_reg       <= ok_next;
            occ_reg      <= occ_ext[OW-1:0];
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next == CW'(DEPTH - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cdeq_pkg::OUT_TDATA_W - BW - OW - 3){1'b0}},
                       full_reg, empty_reg, occ_reg, ok_reg, data_out_reg};

    // chain of cells; cell 0 takes the incoming byte from the left
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        logic [BW-1:0] f_left, f_right, b_left, b_right;

        if (i == 0)
        begin : g_head
            assign f_left = data_in;
            assign b_left = data_in;
        end
        else
        begin : g_mid
            assign f_left = f_val[i-1];
            assign b_left = b_val[i-1];
        end

        if (i == NCELLS - 1)
        begin : g_tail
            assign f_right = '0;
            assign b_right = '0;
        end
        else
        begin : g_body
            assign f_right = f_val[i+1];
            assign b_right = b_val[i+1];
        end

        cdeq_cell #(
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .count   (count_reg),
            .data_in (data_in),
            .f_left  (f_left),
            .f_right (f_right),
            .b_left  (b_left),
            .b_right (b_right),
            .f_val   (f_val[i]),
            .b_val   (b_val[i])
        );
    end

endmodule

### rtl/cdeq_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// cdeq_cell - one slot of the queue chain
// Holds one byte of the front-ordered lane and one of the back-ordered lane.
// Lane F keeps the front byte in cell 0, lane B keeps the back byte in cell 0;
// shifts move data one cell per transfer, appends land at the cell whose index
// equals the current count.
// ============================================================================
module cdeq_cell #(
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  cdeq_pkg::cdeq_cmd_t          cmd,
    input  logic [CW-1:0]                count,
    input  logic [cdeq_pkg::BYTE_W-1:0]  data_in,
    input  logic [cdeq_pkg::BYTE_W-1:0]  f_left,   // lane F, cell towards front
    input  logic [cdeq_pkg::BYTE_W-1:0]  f_right,  // lane F, cell towards back
    input  logic [cdeq_pkg::BYTE_W-1:0]  b_left,   // lane B, cell towards back end
    input  logic [cdeq_pkg::BYTE_W-1:0]  b_right,
    output logic [cdeq_pkg::BYTE_W-1:0]  f_val,
    output logic [cdeq_pkg::BYTE_W-1:0]  b_val
);

    logic [cdeq_pkg::BYTE_W-1:0] f_reg, f_next;
    logic [cdeq_pkg::BYTE_W-1:0] b_reg, b_next;
    logic                        at_tail;

    // this cell is the first free one of both lanes
    assign at_tail = (count == CW'(INDEX));

    // lane F: front at cell 0
    always_comb
    begin
        f_next = f_reg;
        if (cmd.push_front)
        begin
            f_next = f_left;
        end
        else if (cmd.pop_front)
        begin
            f_next = f_right;
        end
        else if (cmd.push_back && at_tail)
        begin
            f_next = data_in;
        end
    end

    // lane B: back at cell 0, mirror of lane F
    always_comb
    begin
        b_next = b_reg;
        if (cmd.push_back)
        begin
            b_next = b_left;
        end
        else if (cmd.pop_back)
        begin
            b_next = b_right;
        end
        else if (cmd.push_front && at_tail)
        begin
            b_next = data_in;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        b_reg <= b_next;
    end

    assign f_val = f_reg;
    assign b_val = b_reg;

endmodule

### rtl/cdeq_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cdeq_checker - port-level checks for the double-ended byte queue
// Watches the stream ports of the top level only; attached by bind.
// ============================================================================
module cdeq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [cdeq_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cdeq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    logic       r_ok, r_empty, r_full;
    logic [7:0] r_data;

    assign r_data  = m_tdata[7:0];
    assign r_ok    = m_tdata[8];
    assign r_empty = m_tdata[16];
    assign r_full  = m_tdata[17];

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // with no result waiting the input side must be open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output stage");

    // a failed request or a push returns a zero byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1] == 1'b0) |=> r_data == 8'h00)
        else $error("push returned a nonzero byte");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !r_ok |-> r_data == 8'h00)
        else $error("failed request returned a nonzero byte");

    // the queue cannot be empty and full at once
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(r_empty && r_full))
        else $error("empty and full both set");

endmodule

bind circular_double_ended_queue_unit cdeq_checker u_cdeq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
